/* hdl/ple_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ple_pkg: shared types and constants of the positional list engine
// Command and status codes, the chain control word and field widths.
// ----------------------------------------------------------------------------
package ple_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int VAL_W = 32;
    localparam int POS_W = 7;
    localparam int CMD_W = 3;
    localparam int STAT_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_INS_FRONT = 3'd0,
        CMD_INS_BACK  = 3'd1,
        CMD_INS_AT    = 3'd2,
        CMD_DEL_FRONT = 3'd3,
        CMD_DEL_BACK  = 3'd4,
        CMD_DEL_AT    = 3'd5,
        CMD_DUMP      = 3'd6
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    // What every cell does in the coming cycle.
    typedef enum logic [1:0] {
        OP_HOLD = 2'd0,
        OP_INS  = 2'd1,
        OP_DEL  = 2'd2,
        OP_ROT  = 2'd3
    } t_chain_op;

    // Broadcast to all cells. For insert and delete, sel is the 0-based slot;
    // for rotate it is the slot of the last held element.
    typedef struct packed {
        t_chain_op         op;
        logic [POS_W-1:0]  sel;
        logic [VAL_W-1:0]  value;
    } t_chain_ctrl;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_DUMP = 1'b1
    } t_state;

endpackage : ple_pkg
`default_nettype wire

/* hdl/ple_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ple_if: request and response channels of the positional list engine
// Valid/ready channels; a transfer happens when both are high at a clock edge.
// ----------------------------------------------------------------------------
interface ple_req_if;
    logic              valid;
    logic              ready;
    logic [2:0]        cmd;
    logic signed [31:0] value;
    logic [6:0]        position;

    modport source (output valid, cmd, value, position, input ready);
    modport sink   (input valid, cmd, value, position, output ready);
endinterface : ple_req_if

interface ple_rsp_if;
    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic [6:0]        count;
    logic signed [31:0] element;
    logic              last;

    modport source (output valid, status, count, element, last, input ready);
    modport sink   (input valid, status, count, element, last, output ready);
endinterface : ple_rsp_if
`default_nettype wire

/* hdl/positional_list_engine.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// positional_list_engine: bounded ordered list of signed 32-bit values
// Insert and delete at front, back or position, and dump, on a cell chain.
// ----------------------------------------------------------------------------
// Usage:
// A request on i_req carries cmd, value and a 1-based position. Every
// request gives one or more responses on o_rsp, each with a status, the
// element count after the request, an element (nonzero only in a dump) and
// a last flag set on the final response of that request.
// Insert and delete requests shift the whole chain of DEPTH cells at once,
// and the response appears in the output register in the cycle after
// acceptance. A new request is taken in the same cycle in which the previous
// response is taken, so these run at one per cycle while o_rsp.ready is high.
// A dump streams count responses, one per cycle while o_rsp.ready allows,
// read from the head cell while the occupied cells rotate by one place;
// after count rotations the list is back in its original order. The first
// dump response comes from the dump state, since the accepting cycle only
// enters the dump state. No request is taken during a dump; a dump of an
// empty list gives one EMPTY response and does not enter the dump state.
// Reset clears the element count and the control state; cell contents are
// not cleared and are never observed before they are written.
// When the receiver holds o_rsp.ready low, the output register keeps its
// response and i_req.ready stays low until the response is taken.
// ----------------------------------------------------------------------------
module positional_list_engine
    import ple_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ple_req_if.sink   i_req,
    ple_rsp_if.source o_rsp
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    // Control state
    t_state           r_state,   n_state;
    logic [CW-1:0]    r_count,   n_count;
    logic [CW-1:0]    r_dump_idx, n_dump_idx;
    logic             r_o_valid, n_o_valid;

    // Response payload
    t_status          r_status,  n_status;
    logic [POS_W-1:0] r_rcount,  n_rcount;
    logic [VAL_W-1:0] r_element, n_element;
    logic             r_last,    n_last;

    t_chain_ctrl      chain_ctrl;
    logic [VAL_W-1:0] head_data;
    logic             out_free;
    logic [POS_W-1:0] cnt7;
    logic             dump_last;
    logic             req_ready;

    assign out_free  = !r_o_valid || o_rsp.ready;
    assign cnt7      = POS_W'(r_count);
    assign dump_last = (r_dump_idx == r_count - CW'(1));

    ple_chain #(
        .DEPTH (DEPTH)
    ) u_chain (
        .i_clk  (i_clk),
        .i_ctrl (chain_ctrl),
        .o_head (head_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_dump_idx <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_dump_idx <= n_dump_idx;
            r_o_valid  <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status  <= n_status;
        r_rcount  <= n_rcount;
        r_element <= n_element;
        r_last    <= n_last;
    end

    always_comb begin
        n_state          = r_state;
        n_count          = r_count;
        n_dump_idx       = r_dump_idx;
        n_o_valid        = r_o_valid && !o_rsp.ready;
        n_status         = r_status;
        n_rcount         = r_rcount;
        n_element        = r_element;
        n_last           = r_last;
        req_ready        = 1'b0;
        chain_ctrl.op    = OP_HOLD;
        chain_ctrl.sel   = '0;
        chain_ctrl.value = i_req.value;

        unique case (r_state)
            S_IDLE: begin
                req_ready = out_free;
                if (i_req.valid && out_free) begin
                    n_o_valid = 1'b1;
                    n_status  = ST_OK;
                    n_element = '0;
                    n_last    = 1'b1;
                    case (i_req.cmd) inside
                        CMD_INS_FRONT, CMD_INS_BACK: begin
                            if (r_count == CNT_FULL) begin
                                n_status = ST_FULL;
                            end else begin
                                chain_ctrl.op  = OP_INS;
                                chain_ctrl.sel = (i_req.cmd == CMD_INS_FRONT) ? '0 : cnt7;
                                n_count        = r_count + CW'(1);
                            end
                        end
                        CMD_INS_AT: begin
                            if (i_req.position == '0 || i_req.position > cnt7 + POS_W'(1)) begin
                                n_status = ST_BADPOS;
                            end else if (r_count == CNT_FULL) begin
                                n_status = ST_FULL;
                            end else begin
                                chain_ctrl.op  = OP_INS;
                                chain_ctrl.sel = i_req.position - POS_W'(1);
                                n_count        = r_count + CW'(1);
                            end
                        end
                        CMD_DEL_FRONT, CMD_DEL_BACK: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                chain_ctrl.op  = OP_DEL;
                                chain_ctrl.sel = (i_req.cmd == CMD_DEL_FRONT)
                                                 ? '0 : cnt7 - POS_W'(1);
                                n_count        = r_count - CW'(1);
                            end
                        end
                        CMD_DEL_AT: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else if (i_req.position == '0 || i_req.position > cnt7) begin
                                n_status = ST_BADPOS;
                            end else begin
                                chain_ctrl.op  = OP_DEL;
                                chain_ctrl.sel = i_req.position - POS_W'(1);
                                n_count        = r_count - CW'(1);
                            end
                        end
                        CMD_DUMP: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                // Responses come from the dump state instead.
                                n_o_valid  = 1'b0;
                                n_dump_idx = '0;
                                n_state    = S_DUMP;
                            end
                        end
                        default: begin
                            n_status = ST_OK;
                        end
                    endcase
                    n_rcount = POS_W'(n_count);
                end
            end
            S_DUMP: begin
                if (out_free) begin
                    n_o_valid      = 1'b1;
                    n_status       = ST_OK;
                    n_rcount       = cnt7;
                    n_element      = head_data;
                    n_last         = dump_last;
                    chain_ctrl.op  = OP_ROT;
                    chain_ctrl.sel = cnt7 - POS_W'(1);
                    n_dump_idx     = r_dump_idx + CW'(1);
                    if (dump_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign i_req.ready   = req_ready;
    assign o_rsp.valid   = r_o_valid;
    assign o_rsp.status  = r_status;
    assign o_rsp.count   = r_rcount;
    assign o_rsp.element = r_element;
    assign o_rsp.last    = r_last;

    // The element count never exceeds the chain length.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("element count above depth");

    // A dump only runs over a non-empty list.
    a_dump_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DUMP |-> r_count != '0)
        else $error("dump running on empty list");

    // A non-dump request gives its single final response in the next cycle.
    a_single_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_req.valid && i_req.ready && i_req.cmd != CMD_DUMP)
        |=> (r_o_valid && r_last))
        else $error("missing response for request");

    // The final dump response returns the engine to idle.
    a_dump_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DUMP && out_free && dump_last)
        |=> (r_state == S_IDLE && r_o_valid && r_last))
        else $error("dump did not finish on its last element");

endmodule : positional_list_engine
`default_nettype wire

/* hdl/ple_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ple_cell: one storage slot of the element chain
// Holds one value and takes it from a neighbor, the head or the request.
// ----------------------------------------------------------------------------
module ple_cell
    import ple_pkg::*;
#(
    parameter int IDX = 0
) (
    input  wire logic              i_clk,
    input  wire t_chain_ctrl       i_ctrl,
    input  wire logic [VAL_W-1:0]  i_left,
    input  wire logic [VAL_W-1:0]  i_right,
    input  wire logic [VAL_W-1:0]  i_head,
    output logic      [VAL_W-1:0]  o_data
);

    localparam logic [POS_W-1:0] CELL_IDX = POS_W'(IDX);

    logic [VAL_W-1:0] r_data;
    logic [VAL_W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        unique case (i_ctrl.op)
            OP_INS: begin
                if (CELL_IDX == i_ctrl.sel) begin
                    n_data = i_ctrl.value;
                end else if (CELL_IDX > i_ctrl.sel) begin
                    n_data = i_left;
                end
            end
            OP_DEL: begin
                if (CELL_IDX >= i_ctrl.sel) begin
                    n_data = i_right;
                end
            end
            OP_ROT: begin
                if (CELL_IDX == i_ctrl.sel) begin
                    n_data = i_head;
                end else if (CELL_IDX < i_ctrl.sel) begin
                    n_data = i_right;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule : ple_cell
`default_nettype wire

/* hdl/ple_chain.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ple_chain: row of DEPTH cells holding the list in order
// Each cell sees both neighbors and the head so the whole row shifts together.
// ----------------------------------------------------------------------------
module ple_chain
    import ple_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  wire logic              i_clk,
    input  wire t_chain_ctrl       i_ctrl,
    output logic      [VAL_W-1:0]  o_head
);

    logic [VAL_W-1:0] cell_data [DEPTH];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [VAL_W-1:0] left_data;
        logic [VAL_W-1:0] right_data;

        // Edge cells see themselves where no neighbor exists.
        if (g == 0) begin : g_first
            assign left_data = cell_data[g];
        end else begin : g_mid_l
            assign left_data = cell_data[g-1];
        end
        if (g == DEPTH - 1) begin : g_final
            assign right_data = cell_data[g];
        end else begin : g_mid_r
            assign right_data = cell_data[g+1];
        end

        ple_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (i_ctrl),
            .i_left  (left_data),
            .i_right (right_data),
            .i_head  (cell_data[0]),
            .o_data  (cell_data[g])
        );
    end

    assign o_head = cell_data[0];

endmodule : ple_chain
`default_nettype wire

/* tb/positional_list_engine_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// positional_list_engine_tb: self-checking bench for the positional list engine
// Feeds list commands through the request channel with random idle cycles,
// follows the list contents in a local copy and checks every response field
// by field as it is taken from the response channel, under random stalls.
// ----------------------------------------------------------------------------
module positional_list_engine_tb;
    import ple_pkg::*;

    localparam int LIST_DEPTH = DEPTH_DEFAULT;
    // The command field has one spare code. The engine must answer it with a
    // plain OK response that leaves the list alone.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
    // Cycles allowed after the last response before the verdict, to catch
    // any response that should never have come.
    localparam int TAIL_CYCLES = 20;
    localparam int RANDOM_REQUESTS = 220;

    // One list command as carried by a request.
    typedef struct {
        logic [CMD_W-1:0]        cmd;
        logic signed [VAL_W-1:0] value;
        logic [POS_W-1:0]        position;
    } t_list_req;

    // One response as the engine should produce it.
    typedef struct {
        t_status                 status;
        logic [POS_W-1:0]        count;
        logic signed [VAL_W-1:0] element;
        logic                    last;
    } t_list_rsp;

    // Biases for the random stimulus: grow the list, shrink it, or both.
    typedef enum int {
        GEN_FILL,
        GEN_DRAIN,
        GEN_MIXED
    } t_gen_mode;

    logic clk;
    logic rst_n;

    ple_req_if req_if ();
    ple_rsp_if rsp_if ();

    positional_list_engine #(
        .DEPTH(LIST_DEPTH)
    ) dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_req  (req_if),
        .o_rsp  (rsp_if)
    );

    // Requests waiting to be driven, filled up front by the stimulus block.
    t_list_req req_backlog[$];
    // The list as it should stand after every request accepted so far.
    logic signed [VAL_W-1:0] list_contents[$];
    // Responses owed by the engine, oldest first.
    t_list_rsp owed_rsp[$];

    int error_count = 0;

    // Driver and monitor bookkeeping; the stimulus block sets the flags up first.
    int req_idle;
    bit req_no_idle;
    t_list_req taken_req;
    t_list_req next_req;
    int rsp_stall;
    bit rsp_no_stall;

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Mismatch reporting. Every failure is counted; the printing stops after a
    // while so that a badly broken run does not flood the log.
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        if (error_count < 40)
            $display("ERROR at %0t ns: %s", $time, what);
        error_count++;
    endtask

    // ------------------------------------------------------------------------
    // List prediction. Applies one accepted request to the local copy of the
    // list and queues the responses that the engine owes for it.
    // ------------------------------------------------------------------------
    task automatic apply_to_list(input t_list_req r);
        t_list_rsp rsp;
        int held;
        held = list_contents.size();
        rsp.status  = ST_OK;
        rsp.element = '0;
        rsp.last    = 1'b1;
        case (r.cmd) inside
            CMD_INS_FRONT, CMD_INS_BACK: begin
                if (held >= LIST_DEPTH)
                    rsp.status = ST_FULL;
                else if (r.cmd == CMD_INS_FRONT)
                    list_contents.push_front(r.value);
                else
                    list_contents.push_back(r.value);
            end
            CMD_INS_AT: begin
                // A bad position wins over a full list.
                if (r.position < 1 || r.position > held + 1)
                    rsp.status = ST_BADPOS;
                else if (held >= LIST_DEPTH)
                    rsp.status = ST_FULL;
                else
                    list_contents.insert(r.position - 1, r.value);
            end
            CMD_DEL_FRONT, CMD_DEL_BACK: begin
                if (held == 0)
                    rsp.status = ST_EMPTY;
                else if (r.cmd == CMD_DEL_FRONT)
                    void'(list_contents.pop_front());
                else
                    void'(list_contents.pop_back());
            end
            CMD_DEL_AT: begin
                // An empty list reports empty whatever the position says.
                if (held == 0)
                    rsp.status = ST_EMPTY;
                else if (r.position < 1 || r.position > held)
                    rsp.status = ST_BADPOS;
                else
                    list_contents.delete(r.position - 1);
            end
            CMD_DUMP: begin
                if (held == 0) begin
                    rsp.status = ST_EMPTY;
                end else begin
                    // A dump streams every element, first to last, and flags
                    // only the final one.
                    for (int i = 0; i < held; i++) begin
                        rsp.count   = POS_W'(held);
                        rsp.element = list_contents[i];
                        rsp.last    = (i == held - 1);
                        owed_rsp.push_back(rsp);
                    end
                    return;
                end
            end
            default: begin
                // The spare command code does nothing but answer.
            end
        endcase
        rsp.count = POS_W'(list_contents.size());
        owed_rsp.push_back(rsp);
    endtask

    // ------------------------------------------------------------------------
    // Response check against the oldest owed response.
    // ------------------------------------------------------------------------
    task automatic check_response();
        t_list_rsp want;
        if (owed_rsp.size() == 0) begin
            report_mismatch($sformatf("response with none owed: status %0d count %0d element %0d",
                                      rsp_if.status, rsp_if.count, rsp_if.element));
            return;
        end
        want = owed_rsp.pop_front();
        if (rsp_if.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", rsp_if.status, want.status));
        if (rsp_if.count !== want.count)
            report_mismatch($sformatf("count %0d, expected %0d", rsp_if.count, want.count));
        if (rsp_if.element !== want.element)
            report_mismatch($sformatf("element %0d, expected %0d",
                                      rsp_if.element, want.element));
        if (rsp_if.last !== want.last)
            report_mismatch($sformatf("last %0b, expected %0b", rsp_if.last, want.last));
    endtask

    // ------------------------------------------------------------------------
    // Request driver. A request stays on the channel until it is accepted; its
    // effect on the list is predicted at the edge where it is accepted. After
    // each request the driver idles for a drawn number of cycles, except in
    // stretches where idling is switched off.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            req_if.valid <= 1'b0;
            req_idle = 0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                taken_req.cmd      = req_if.cmd;
                taken_req.value    = req_if.value;
                taken_req.position = req_if.position;
                apply_to_list(taken_req);
            end
            if (req_if.valid && !req_if.ready) begin
                // Still waiting for the engine to take it.
            end else if (req_idle > 0) begin
                req_if.valid <= 1'b0;
                req_idle--;
            end else if (req_backlog.size() != 0) begin
                next_req = req_backlog.pop_front();
                req_if.valid    <= 1'b1;
                req_if.cmd      <= next_req.cmd;
                req_if.value    <= next_req.value;
                req_if.position <= next_req.position;
                if ($urandom_range(0, 15) == 0)
                    req_no_idle = !req_no_idle;
                req_idle = req_no_idle ? 0 : $urandom_range(0, 7);
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Response monitor. Each taken response is checked; the receiver then
    // stalls for a drawn number of cycles, which also lands stalls in the
    // middle of a dump stream.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            rsp_if.ready <= 1'b0;
            rsp_stall = 0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                check_response();
                if ($urandom_range(0, 15) == 0)
                    rsp_no_stall = !rsp_no_stall;
                rsp_stall = rsp_no_stall ? 0 : $urandom_range(0, 7);
            end
            if (rsp_stall > 0) begin
                rsp_if.ready <= 1'b0;
                rsp_stall--;
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus generation
    // ------------------------------------------------------------------------

    // Rough element count that the generator keeps so that most positions it
    // draws are in range. It only steers the stimulus; checking does not use it.
    int planned_count = 0;

    function automatic int count_after(input t_list_req r, input int n);
        case (r.cmd) inside
            CMD_INS_FRONT, CMD_INS_BACK:
                return (n < LIST_DEPTH) ? n + 1 : n;
            CMD_INS_AT:
                return (r.position >= 1 && r.position <= n + 1 && n < LIST_DEPTH) ? n + 1 : n;
            CMD_DEL_FRONT, CMD_DEL_BACK:
                return (n > 0) ? n - 1 : n;
            CMD_DEL_AT:
                return (r.position >= 1 && r.position <= n) ? n - 1 : n;
            default:
                return n;
        endcase
    endfunction

    task automatic queue_request(input logic [CMD_W-1:0] cmd,
                                 input logic signed [VAL_W-1:0] value,
                                 input logic [POS_W-1:0] position);
        t_list_req r;
        r.cmd      = cmd;
        r.value    = value;
        r.position = position;
        planned_count = count_after(r, planned_count);
        req_backlog.push_back(r);
    endtask

    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return -32'sd1;
            3:       return '0;
            default: return $urandom;
        endcase
    endfunction

    // Draws one random request. Most positions are legal for the planned
    // count; the rest span the whole field.
    task automatic queue_random_request(input t_gen_mode mode);
        logic [CMD_W-1:0] cmd;
        logic [POS_W-1:0] position;
        int roll;
        int insert_share;
        insert_share = (mode == GEN_FILL) ? 80 : (mode == GEN_DRAIN) ? 20 : 50;
        roll = $urandom_range(0, 99);
        if (roll < 2) begin
            cmd = CMD_UNUSED;
        end else if (roll < 12) begin
            cmd = CMD_DUMP;
        end else if ($urandom_range(0, 99) < insert_share) begin
            case ($urandom_range(0, 2))
                0:       cmd = CMD_INS_FRONT;
                1:       cmd = CMD_INS_BACK;
                default: cmd = CMD_INS_AT;
            endcase
        end else begin
            case ($urandom_range(0, 2))
                0:       cmd = CMD_DEL_FRONT;
                1:       cmd = CMD_DEL_BACK;
                default: cmd = CMD_DEL_AT;
            endcase
        end

        position = POS_W'($urandom_range(0, 127));
        if ($urandom_range(0, 99) < 85) begin
            if (cmd == CMD_INS_AT)
                position = POS_W'($urandom_range(1, planned_count + 1));
            else if (cmd == CMD_DEL_AT && planned_count > 0)
                position = POS_W'($urandom_range(1, planned_count));
        end
        queue_request(cmd, pick_value(), position);
    endtask

    initial begin : stimulus
        int made;
        int run_len;
        t_gen_mode mode;

        rst_n           = 1'b0;
        req_if.valid    = 1'b0;
        req_if.cmd      = '0;
        req_if.value    = '0;
        req_if.position = '0;
        rsp_if.ready    = 1'b0;
        req_no_idle     = 1'b0;
        rsp_no_stall    = 1'b0;

        // Directed opening: dump, deletes and inserts on an empty list, the extremes of
        // the value and position fields, a full list and the position checks.
        queue_request(CMD_DUMP, '0, '0);                  // dump of an empty list
        queue_request(CMD_DEL_FRONT, '0, '0);             // deletes from an empty list
        queue_request(CMD_DEL_BACK, '0, '0);
        queue_request(CMD_DEL_AT, '0, 7'd5);
        queue_request(CMD_INS_AT, 32'sd11, 7'd0);         // position zero
        queue_request(CMD_INS_AT, 32'sd12, 7'd2);         // past count+1
        queue_request(CMD_INS_FRONT, 32'sh7FFF_FFFF, '0);
        queue_request(CMD_INS_BACK, 32'sh8000_0000, 7'd127);
        queue_request(CMD_INS_AT, -32'sd1, 7'd2);         // into the middle
        queue_request(CMD_INS_AT, '0, 7'd4);              // at count+1, the tail
        queue_request(CMD_UNUSED, 32'sh5A5A_5A5A, 7'd3);  // spare command code
        queue_request(CMD_DUMP, '0, '0);
        queue_request(CMD_DEL_AT, '0, 7'd0);              // bad delete positions
        queue_request(CMD_DEL_AT, '0, 7'd127);
        queue_request(CMD_DEL_AT, '0, 7'd4);              // delete at the last position
        queue_request(CMD_INS_AT, 32'sd13, 7'd127);
        while (planned_count < LIST_DEPTH)
            queue_request(CMD_INS_BACK, $urandom, '0);
        queue_request(CMD_INS_FRONT, 32'sd21, '0);        // inserts into a full list
        queue_request(CMD_INS_AT, 32'sd22, 7'd17);
        queue_request(CMD_INS_AT, 32'sd23, 7'd18);        // bad position beats full
        queue_request(CMD_DUMP, '0, '0);                  // longest dump
        queue_request(CMD_DEL_AT, '0, 7'd1);

        // Random part in runs that push the list toward full, toward empty,
        // or keep it in the middle.
        made = 0;
        while (made < RANDOM_REQUESTS) begin
            mode    = t_gen_mode'($urandom_range(0, 2));
            run_len = $urandom_range(10, 40);
            for (int i = 0; i < run_len && made < RANDOM_REQUESTS; i++) begin
                queue_random_request(mode);
                made++;
            end
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every request to be taken, then for every owed response.
        while (req_backlog.size() != 0 || req_if.valid)
            @(posedge clk);
        while (owed_rsp.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Watchdog. A correct run with the longest dumps, stalls and idles takes
    // well under half a millisecond.
    // ------------------------------------------------------------------------
    initial begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule : positional_list_engine_tb
